// ===== rtl/ecr_pkg.sv =====
package ecr_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned ROOT_W  = 22;

  // Largest root the search covers; 2642245 is the largest cube root below 2^64
  localparam logic [ROOT_W-1:0] SEARCH_HIGH = ROOT_W'(2642245);

  // 3-bit digits per value, top digit padded with zeros
  localparam int unsigned DIG_W   = 3;
  localparam int unsigned N_DIGS  = (VALUE_W + DIG_W - 1) / DIG_W;
  localparam int unsigned SHR_W   = N_DIGS * DIG_W;
  localparam int unsigned CNT_W   = $clog2(N_DIGS);

  // remainder and 3*y^2 stay below 2^46
  localparam int unsigned REM_W   = 48;

  typedef logic [ROOT_W-1:0] root_t;
  typedef logic [REM_W-1:0]  rem_t;

endpackage

// ===== rtl/exact_cube_root.sv =====
// A word is taken only while busy is low; busy stays high after start for
//   one step per 3-bit digit of the value through the shared add/compare stage,
//   and the result strobe is registered from the last step.
// The result is held on out_* for the single strobe cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears busy and the strobe; data registers are not reset.
module exact_cube_root #(
  parameter logic [ecr_pkg::ROOT_W-1:0] SEARCH_HIGH = ecr_pkg::SEARCH_HIGH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ecr_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  output logic [ecr_pkg::ROOT_W-1:0]    out_root,
  output logic                          out_is_cube
);
  import ecr_pkg::*;

  // Digit-by-digit cube root (restoring form). Per step, with y the partial
  // root and a = 3*y^2 kept incrementally:
  //   rem <- 8*rem + digit,  y' = 2y
  //   t    = 3y'^2 + 3y' + 1 = 4a + 6y + 1
  //   rem >= t : rem -= t, y' += 1, a <- 4a + 12y + 3
  //   else     :                    a <- 4a
  // After all digits y = floor(cbrt(value)); exact iff rem is zero and y <= SEARCH_HIGH.

  logic                   busy_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SHR_W-1:0]       shr_r;
  root_t                  y_r;
  rem_t                   rem_r;
  rem_t                   a_r;

  logic                   out_valid_r;
  root_t                  out_root_r;
  logic                   out_is_cube_r;

  logic                   accept;
  logic                   last;
  logic [DIG_W-1:0]       dig;
  rem_t                   rem_sh;
  rem_t                   a4;
  rem_t                   y6;
  rem_t                   y12;
  rem_t                   t;
  logic                   ge;
  rem_t                   rem_nxt;
  root_t                  y_nxt;
  rem_t                   a_nxt;
  logic                   exact;

  assign accept = start & ~busy_r;
  assign last   = (cnt_r == CNT_W'(N_DIGS - 1));

  // current digit is the top of the shift register
  assign dig    = shr_r[SHR_W-1 -: DIG_W];

  assign rem_sh = {rem_r[REM_W-DIG_W-1:0], dig};
  assign a4     = {a_r[REM_W-3:0], 2'b00};
  assign y6     = REM_W'({y_r, 2'b00}) + REM_W'({y_r, 1'b0});
  assign y12    = {y6[REM_W-2:0], 1'b0};
  assign t      = a4 + y6 + REM_W'(1);
  assign ge     = (rem_sh >= t);

  assign rem_nxt = ge ? (rem_sh - t) : rem_sh;
  assign y_nxt   = {y_r[ROOT_W-2:0], ge};
  assign a_nxt   = ge ? (a4 + y12 + REM_W'(3)) : a4;

  // a cube whose root lies past the search bound is not found
  assign exact   = (rem_nxt == '0) && (y_nxt <= SEARCH_HIGH);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy_r & last;
      if (accept) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (last) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      shr_r <= SHR_W'(in_value);
      y_r   <= '0;
      rem_r <= '0;
      a_r   <= '0;
    end else if (busy_r) begin
      shr_r <= {shr_r[SHR_W-DIG_W-1:0], {DIG_W{1'b0}}};
      y_r   <= y_nxt;
      rem_r <= rem_nxt;
      a_r   <= a_nxt;
    end
    if (busy_r & last) begin
      out_root_r    <= exact ? y_nxt : '0;
      out_is_cube_r <= exact;
    end
  end

  assign busy        = busy_r;
  assign out_valid   = out_valid_r;
  assign out_root    = out_root_r;
  assign out_is_cube = out_is_cube_r;

endmodule
